FILE: sv/brig_pkg.sv
// Shared types, constants and helpers of the bounded random integer generator.
package brig_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned HALF_W    = WORD_W / 2;
	localparam int unsigned PROD_W    = 2 * WORD_W;
	localparam int unsigned MUL_PARTS = 4;
	localparam int unsigned MUL_CNT_W = $clog2(MUL_PARTS + 1);
	localparam int unsigned DIV_STEPS = WORD_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Xorshift shift amounts
	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 7;
	localparam int unsigned XS_C = 17;

	localparam logic [WORD_W-1:0] SEED_RESET = 64'd88172645463325252;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic draw;
		logic mul_en;
		logic div_en;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic low_lt_n;
		logic low_lt_thr;
		logic thr_valid;
		logic out_free;
	} status_t;

	// One xorshift step; the new state is also the draw
	function automatic word_t xorshift_next(word_t x);
		word_t t;
		t = x ^ (x << XS_A);
		t = t ^ (t >> XS_B);
		t = t ^ (t << XS_C);
		return t;
	endfunction

endpackage

FILE: sv/brig_ctrl.sv
// Controller state machine: sequences draw, multiply, threshold division and output.
module brig_ctrl
	import brig_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DRAW;
			end
			ST_DRAW: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (st.mul_done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!st.low_lt_n) begin
					state_d = ST_OUT;
				end else if (!st.thr_valid) begin
					state_d = ST_DIV;
				end else if (st.low_lt_thr) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (st.div_done) state_d = ST_CHECK;
			end
			ST_OUT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// An accepted request always starts with a draw
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_DRAW)
		else $error("accepted request did not start a draw");

	// The output register is loaded only when it is free
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over a pending one");

	// The threshold is divided out at most once per request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK && state_d == ST_DIV |-> !st.thr_valid)
		else $error("threshold division repeated");

endmodule

FILE: sv/brig_dp.sv
// Datapath: xorshift generator, shared 32x32 multiplier, radix-2 remainder unit, output register.
module brig_dp
	import brig_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [WORD_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              seed_we,
	input  logic [WORD_W-1:0] seed_wdata,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [WORD_W-1:0] m_tdata,
	output status_t           st
);

	word_t                gen_q;
	word_t                n_q;
	logic                 narrow_q;
	word_t                rem_q;
	word_t                dvd_q;
	logic                 thr_valid_q;
	logic [PROD_W-1:0]    acc_q;
	word_t                prod_s1;
	logic [1:0]           idx_s1;
	logic [MUL_CNT_W-1:0] mcnt_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	word_t                value_q;
	logic                 m_tvalid_q;

	word_t             n_in, neg_in, dvd_in;
	logic [HALF_W-1:0] a_half, b_half;
	word_t             pp;
	logic [PROD_W-1:0] pp_shifted;
	logic              mul_issue, mul_acc, div_last;
	logic [WORD_W:0]   trial, diff;
	word_t             rem_next, low_eff, result;

	// Effective bound and threshold dividend (2^w - n) of the incoming request
	assign n_in   = s_tuser ? {{HALF_W{1'b0}}, s_tdata[HALF_W-1:0]} : s_tdata;
	assign neg_in = '0 - n_in;
	assign dvd_in = s_tuser ? {{HALF_W{1'b0}}, neg_in[HALF_W-1:0]} : neg_in;

	// Multiplier: one 32x32 partial product per cycle, registered and then accumulated
	assign a_half    = mcnt_q[0] ? gen_q[WORD_W-1:HALF_W] : gen_q[HALF_W-1:0];
	assign b_half    = mcnt_q[1] ? n_q[WORD_W-1:HALF_W] : n_q[HALF_W-1:0];
	assign pp        = a_half * b_half;
	assign mul_issue = cmd.mul_en && (mcnt_q < MUL_CNT_W'(MUL_PARTS));
	assign mul_acc   = cmd.mul_en && (mcnt_q != '0);

	always_comb begin
		case (idx_s1)
			2'd0:    pp_shifted = {{WORD_W{1'b0}}, prod_s1};
			2'd1:    pp_shifted = {{HALF_W{1'b0}}, prod_s1, {HALF_W{1'b0}}};
			2'd2:    pp_shifted = {prod_s1, {WORD_W{1'b0}}};
			default: pp_shifted = '0;
		endcase
	end

	// Remainder unit: one restoring step per cycle
	assign trial    = {rem_q, dvd_q[WORD_W-1]};
	assign diff     = trial - {1'b0, n_q};
	assign rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
	assign div_last = cmd.div_en && (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// Low word and result as the width mode selects them
	assign low_eff = narrow_q ? {{HALF_W{1'b0}}, acc_q[HALF_W-1:0]} : acc_q[WORD_W-1:0];
	assign result  = narrow_q ? {{HALF_W{1'b0}}, acc_q[WORD_W-1:HALF_W]}
	                          : acc_q[PROD_W-1:WORD_W];

	// Control state: generator, counters, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= SEED_RESET;
			thr_valid_q <= 1'b0;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (seed_we) begin
				gen_q <= (seed_wdata != '0) ? seed_wdata : SEED_RESET;
			end else if (cmd.draw) begin
				gen_q <= xorshift_next(gen_q);
			end
			if (cmd.load) begin
				thr_valid_q <= 1'b0;
				dcnt_q      <= '0;
			end else if (cmd.div_en) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (div_last) thr_valid_q <= 1'b1;
			end
			if (cmd.draw) begin
				mcnt_q <= '0;
			end else if (mul_issue) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q      <= n_in;
			narrow_q <= s_tuser;
			dvd_q    <= dvd_in;
			rem_q    <= '0;
		end else if (cmd.div_en) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (mul_issue) begin
			prod_s1 <= pp;
			idx_s1  <= 2'(mcnt_q[0]) + 2'(mcnt_q[1]);
		end
		if (cmd.draw) begin
			acc_q <= '0;
		end else if (mul_acc) begin
			acc_q <= acc_q + pp_shifted;
		end
		if (cmd.out_load) begin
			value_q <= result;
		end
	end

	// Status to the controller (rem_q holds the threshold once valid)
	assign st.mul_done   = cmd.mul_en && (mcnt_q == MUL_CNT_W'(MUL_PARTS));
	assign st.div_done   = div_last;
	assign st.low_lt_n   = low_eff < n_q;
	assign st.low_lt_thr = low_eff < rem_q;
	assign st.thr_valid  = thr_valid_q;
	assign st.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = value_q;

	// Xorshift must never reach the all-zero state
	assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != '0)
		else $error("generator state became zero");

	// The finished threshold lies below the bound
	assert property (@(posedge clk) disable iff (!arst_n)
		div_last |=> thr_valid_q && (rem_q < n_q))
		else $error("threshold not reduced below the bound");

	// A multiply pass never overruns its partial products
	assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= MUL_CNT_W'(MUL_PARTS))
		else $error("multiplier step counter overran");

endmodule

FILE: sv/bounded_random_integer_generator.sv
// An accepted request passes a draw, the multiply pass and a compare, then m_tvalid if the first draw is kept.
// The threshold is divided out at most once per request, when a draw first needs it (64 remainder steps, a compare).
// Each redraw repeats the xorshift step, the multiply pass and the compare.
// A new request is taken only once the last result is loaded; a finished result may wait in m_tdata.
// Reset loads the generator with the default seed and clears the controller and m_tvalid;
// a seed write of zero loads the default seed as well.
module bounded_random_integer_generator
	import brig_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// seed register
	input  logic              seed_we,
	input  logic [WORD_W-1:0] seed_wdata,
	// request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,  // [63:0] range_bound
	input  logic              s_tuser,  // [0] narrow_mode
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata   // [63:0] value
);

	cmd_t    cmd;
	status_t st;

	brig_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	brig_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.st         (st)
	);

endmodule
